[src/bpal_pkg.sv]
package bpal_pkg;

	// default number of chords
	localparam int SEGMENTS_DEF = 32;

	// fixed point constants
	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [37:0] LEN_MAX = '1;

	// square root: 33 result bits from a 66-bit radicand
	localparam int SQ_STEPS = 33;

	// widths sized for the largest segment count (256)
	localparam int R_W   = 8;
	localparam int TOT_W = 43;

	// item state handed from cell to cell
	typedef struct packed {
		logic signed [31:0] x0;
		logic signed [31:0] y0;
		logic signed [31:0] x1;
		logic signed [31:0] y1;
		logic signed [31:0] x2;
		logic signed [31:0] y2;
		logic [16:0]        tq;
		logic [R_W-1:0]     tr;
		logic [16:0]        q;
		logic [R_W-1:0]     r;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic [TOT_W-1:0]   total;
	} bpal_item_t;

endpackage

[src/bpal_cell.sv]
module bpal_cell import bpal_pkg::*; #(
	parameter int SEGMENTS = SEGMENTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic       in_valid,
	input  bpal_item_t in_item,
	output logic       out_valid,
	output bpal_item_t out_item
);

	// next parameter sample: s += t / SEGMENTS with carried remainder
	logic [R_W:0] r_sum;
	logic         r_wrap;
	bpal_item_t   item_n;

	always_comb begin
		r_sum  = {1'b0, in_item.r} + {1'b0, in_item.tr};
		r_wrap = r_sum >= (R_W+1)'(SEGMENTS);
		item_n = in_item;
		item_n.q = in_item.q + in_item.tq + 17'(r_wrap);
		item_n.r = r_wrap ? R_W'(r_sum - (R_W+1)'(SEGMENTS)) : r_sum[R_W-1:0];
	end

	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	bpal_item_t  item_s1, item_s2, item_s3, item_s4, item_s5, item_s6, item_s7;
	logic [16:0] u_s1;
	logic [32:0] w0_s2, w1_s2, w2_s2;
	logic signed [65:0] bx0_s3, bx1_s3, bx2_s3, by0_s3, by1_s3, by2_s3;
	logic signed [31:0] nx_s4, ny_s4;
	logic [31:0] ax_s5, ay_s5;
	logic [63:0] sx_s6, sy_s6;
	logic [64:0] rad_s7;

	// weights, sample point, chord deltas
	logic [33:0]        uu, us, ss;
	logic signed [33:0] ws0, ws1, ws2;
	logic signed [65:0] sum_x, sum_y;
	logic signed [32:0] dx, dy;
	bpal_item_t         item_pt;

	always_comb begin
		uu    = 34'(u_s1) * 34'(u_s1);
		us    = 34'(u_s1) * 34'(item_s1.q);
		ss    = 34'(item_s1.q) * 34'(item_s1.q);
		ws0   = {1'b0, w0_s2};
		ws1   = {1'b0, w1_s2};
		ws2   = {1'b0, w2_s2};
		sum_x = bx0_s3 + bx1_s3 + bx2_s3 + 66'sd2147483648;
		sum_y = by0_s3 + by1_s3 + by2_s3 + 66'sd2147483648;
		dx    = 33'(nx_s4) - 33'(item_s4.px);
		dy    = 33'(ny_s4) - 33'(item_s4.py);
		// new sample becomes the previous point of the next cell
		item_pt    = item_s4;
		item_pt.px = nx_s4;
		item_pt.py = ny_s4;
	end

	// valid bits of the arithmetic stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// arithmetic stages
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= item_n;
			u_s1    <= ONE_Q16 - item_n.q;

			item_s2 <= item_s1;
			w0_s2   <= uu[32:0];
			w1_s2   <= {us[31:0], 1'b0};
			w2_s2   <= ss[32:0];

			item_s3 <= item_s2;
			bx0_s3  <= 66'(item_s2.x0) * 66'(ws0);
			bx1_s3  <= 66'(item_s2.x1) * 66'(ws1);
			bx2_s3  <= 66'(item_s2.x2) * 66'(ws2);
			by0_s3  <= 66'(item_s2.y0) * 66'(ws0);
			by1_s3  <= 66'(item_s2.y1) * 66'(ws1);
			by2_s3  <= 66'(item_s2.y2) * 66'(ws2);

			item_s4 <= item_s3;
			nx_s4   <= sum_x[63:32];
			ny_s4   <= sum_y[63:32];

			item_s5    <= item_pt;
			ax_s5      <= dx[32] ? 32'(-dx) : dx[31:0];
			ay_s5      <= dy[32] ? 32'(-dy) : dy[31:0];

			item_s6 <= item_s5;
			sx_s6   <= 64'(ax_s5) * 64'(ax_s5);
			sy_s6   <= 64'(ay_s5) * 64'(ay_s5);

			item_s7 <= item_s6;
			rad_s7  <= 65'(sx_s6) + 65'(sy_s6);
		end
	end

	// square root, one result bit per stage
	logic        sq_v    [0:SQ_STEPS];
	bpal_item_t  sq_item [0:SQ_STEPS];
	logic [65:0] sq_rad  [0:SQ_STEPS];
	logic [34:0] sq_rem  [0:SQ_STEPS];
	logic [32:0] sq_root [0:SQ_STEPS];

	assign sq_v[0]    = v_s7;
	assign sq_item[0] = item_s7;
	assign sq_rad[0]  = {1'b0, rad_s7};
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
		logic [36:0] cur, trial;
		logic        fit;

		always_comb begin
			cur   = {sq_rem[k], sq_rad[k][65:64]};
			trial = {2'b00, sq_root[k], 2'b01};
			fit   = cur >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[k+1] <= 1'b0;
			end else if (adv) begin
				sq_v[k+1] <= sq_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_item[k+1] <= sq_item[k];
				sq_rad[k+1]  <= {sq_rad[k][63:0], 2'b00};
				sq_rem[k+1]  <= fit ? 35'(cur - trial) : cur[34:0];
				sq_root[k+1] <= {sq_root[k][31:0], fit};
			end
		end
	end

	// round to nearest and add the chord to the running sum
	logic       rnd_up;
	bpal_item_t item_acc;
	assign rnd_up = sq_rem[SQ_STEPS] > {2'b00, sq_root[SQ_STEPS]};

	always_comb begin
		item_acc       = sq_item[SQ_STEPS];
		item_acc.total = sq_item[SQ_STEPS].total + TOT_W'(sq_root[SQ_STEPS])
			+ TOT_W'(rnd_up);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= sq_v[SQ_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_item <= item_acc;
		end
	end

endmodule

[src/bezier2_polyline_arc_length.sv]
// channel | dir | tdata                                     | tuser     | tlast
// s_      | in  | p0_x p0_y p1_x p1_y p2_x p2_y t_limit     | -         | -
// m_      | out | arc_length                                | saturated | -
//
// one curve per cycle unless the output stalls; input register, chain entry register, cells, output register
// each cell is one chord: 7 arithmetic stages, 33 root stages, 1 sum stage
// reset clears every valid bit; payload registers are not reset
// a stalled output freezes the whole chain, and s_tready follows it
module bezier2_polyline_arc_length import bpal_pkg::*; #(
	parameter int SEGMENTS = SEGMENTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// p0_x[31:0] p0_y p1_x p1_y p2_x p2_y t_limit[16:0], zero pad to 216
	input  logic [215:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// arc_length[37:0], zero pad to 40
	output logic [39:0]  m_tdata,
	// saturated
	output logic         m_tuser
);

	localparam int RCP_SH = 25;
	localparam logic [RCP_SH:0] RCP = (RCP_SH+1)'((64'd1 << RCP_SH) / SEGMENTS);

	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// clamp t and start the division by the segment count
	logic [16:0] t_in, t_cl;
	assign t_in = s_tdata[208:192];
	assign t_cl = (t_in > ONE_Q16) ? ONE_Q16 : t_in;

	logic        v_a;
	logic [16:0] t_a;
	logic [41:0] prod_a;
	logic [191:0] pts_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_a <= 1'b0;
		end else if (adv) begin
			v_a <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_a    <= t_cl;
			prod_a <= 42'(t_cl) * 42'(RCP);
			pts_a  <= s_tdata[191:0];
		end
	end

	// quotient correction and first cell input
	logic [16:0] q_est;
	logic [25:0] r_est;
	logic        q_fix;
	bpal_item_t  item_b;

	always_comb begin
		q_est        = prod_a[RCP_SH+16:RCP_SH];
		r_est        = 26'(t_a) - 26'(q_est) * 26'(SEGMENTS);
		q_fix        = r_est >= 26'(SEGMENTS);
		item_b.x0    = pts_a[31:0];
		item_b.y0    = pts_a[63:32];
		item_b.x1    = pts_a[95:64];
		item_b.y1    = pts_a[127:96];
		item_b.x2    = pts_a[159:128];
		item_b.y2    = pts_a[191:160];
		item_b.tq    = q_est + 17'(q_fix);
		item_b.tr    = q_fix ? R_W'(r_est - 26'(SEGMENTS)) : r_est[R_W-1:0];
		item_b.q     = '0;
		item_b.r     = '0;
		item_b.px    = pts_a[31:0];
		item_b.py    = pts_a[63:32];
		item_b.total = '0;
	end

	logic       chain_v    [0:SEGMENTS];
	bpal_item_t chain_item [0:SEGMENTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_v[0] <= 1'b0;
		end else if (adv) begin
			chain_v[0] <= v_a;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			chain_item[0] <= item_b;
		end
	end

	// one cell per chord
	for (genvar c = 0; c < SEGMENTS; c++) begin : g_cell
		bpal_cell #(
			.SEGMENTS(SEGMENTS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_valid (chain_v[c]),
			.in_item  (chain_item[c]),
			.out_valid(chain_v[c+1]),
			.out_item (chain_item[c+1])
		);
	end

	// saturate and hold the result beat
	logic [TOT_W-1:0] tot;
	logic             sat;
	assign tot = chain_item[SEGMENTS].total;
	assign sat = tot > TOT_W'(LEN_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= chain_v[SEGMENTS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {2'b00, sat ? LEN_MAX : tot[37:0]};
			m_tuser <= sat;
		end
	end

endmodule

[src/bpal_checker.sv]
module bpal_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [215:0] s_tdata,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [39:0]  m_tdata,
	input logic         m_tuser
);

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// input side never stalls while the output side is empty
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// saturated beat carries the full-scale length
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[37:0] == 38'h3fffffffff)
		else $error("saturated beat without full-scale length");

	// pad bits stay clear
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:38] == 2'b00)
		else $error("pad bits set on result beat");

	// accepted input beat carries known data
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> !$isunknown(s_tdata))
		else $error("unknown bits on accepted input beat");

endmodule

bind bezier2_polyline_arc_length bpal_checker u_bpal_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
